>>> design/i2cram_pkg.sv
// Shared types, constants and program tables for the I2C register access master.
package i2cram_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] CFG_WRITE_ADDR = 2'd0;
  localparam logic [1:0] CFG_READ_ADDR  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  localparam logic [7:0] WRITE_ADDR_RESET = 8'd0;
  localparam logic [7:0] READ_ADDR_RESET  = 8'd1;
  localparam logic [7:0] TIMEOUT_RESET    = 8'd20;

  localparam logic [5:0] PH_IDLE     = 6'd63;
  localparam logic [5:0] PH_BUSY_END = 6'd48;
  localparam logic [3:0] POS_FAIL    = 4'd11;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    K_START,
    K_TX,
    K_ACK,
    K_RX,
    K_NACK,
    K_STOP
  } kind_t;

  typedef enum logic [2:0] {
    S_NONE,
    S_WADDR,
    S_REG,
    S_DATA,
    S_RADDR
  } src_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       push_ready;
    logic       pop_valid;
    logic [1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] write_address_byte;
    logic [7:0] read_address_byte;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       success;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_out;
    logic       scl;
  } res_t;

  function automatic kind_t prog_kind(input logic is_read, input logic [3:0] pos);
    kind_t k;
    k = K_STOP;
    case ({is_read, pos})
      5'd0:  k = K_START;
      5'd1:  k = K_TX;
      5'd2:  k = K_ACK;
      5'd3:  k = K_TX;
      5'd4:  k = K_ACK;
      5'd5:  k = K_TX;
      5'd6:  k = K_ACK;
      5'd16: k = K_START;
      5'd17: k = K_TX;
      5'd18: k = K_ACK;
      5'd19: k = K_TX;
      5'd20: k = K_ACK;
      5'd21: k = K_START;
      5'd22: k = K_TX;
      5'd23: k = K_ACK;
      5'd24: k = K_RX;
      5'd25: k = K_NACK;
      default: k = K_STOP;
    endcase
    return k;
  endfunction

  function automatic src_t prog_src(input logic is_read, input logic [3:0] pos);
    src_t s;
    s = S_NONE;
    case ({is_read, pos})
      5'd1:  s = S_WADDR;
      5'd3:  s = S_REG;
      5'd5:  s = S_DATA;
      5'd17: s = S_WADDR;
      5'd19: s = S_REG;
      5'd22: s = S_RADDR;
      default: s = S_NONE;
    endcase
    return s;
  endfunction

endpackage

>>> design/i2cram_front.sv
// Input stage: registers each accepted item and classifies its command.
module i2cram_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_reg_addr,
  input  logic [7:0]          in_write_data,
  input  logic                in_sda,
  output logic                push,
  output i2cram_pkg::item_t   push_item,
  input  i2cram_pkg::q_stat_t q_stat
);

  logic              valid;
  i2cram_pkg::item_t item;
  i2cram_pkg::op_t   op_next;

  always_comb begin
    case (in_cmd)
      i2cram_pkg::CMD_WRITE: op_next = i2cram_pkg::OP_WRITE;
      i2cram_pkg::CMD_READ:  op_next = i2cram_pkg::OP_READ;
      default:               op_next = i2cram_pkg::OP_TICK;
    endcase
  end

  assign push      = valid && q_stat.push_ready;
  assign in_ready  = !valid || q_stat.push_ready;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op         <= op_next;
      item.reg_addr   <= in_reg_addr;
      item.write_data <= in_write_data;
      item.sda_in     <= in_sda;
    end
  end

endmodule

>>> design/i2cram_queue.sv
// Two-entry queue between the input stage and the bus sequencer.
module i2cram_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cram_pkg::item_t   push_item,
  input  logic                pop,
  output i2cram_pkg::item_t   pop_item,
  output i2cram_pkg::q_stat_t q_stat
);

  localparam int PTR_W = $clog2(i2cram_pkg::QUEUE_DEPTH);

  i2cram_pkg::item_t    entries [i2cram_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [1:0]           count;

  assign q_stat.push_ready = (count != 2'(i2cram_pkg::QUEUE_DEPTH));
  assign q_stat.pop_valid  = (count != 2'd0);
  assign q_stat.count      = count;
  assign pop_item          = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> design/i2cram_back.sv
// Bus sequencer: runs one tick per item and holds the result in an output register.
module i2cram_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              pop_valid,
  input  i2cram_pkg::item_t pop_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cram_pkg::res_t  out_res
);

  i2cram_pkg::cfg_t cfg;

  logic [5:0] phase;
  logic [1:0] hold_count;
  logic [2:0] bit_count;
  logic [7:0] shift_byte;
  logic [7:0] poll_count;
  logic       is_read;
  logic [7:0] latched_register;
  logic [7:0] latched_data;
  logic [7:0] received_byte;
  logic       scl_level;
  logic       sda_level;

  logic [5:0] phase_next;
  logic [1:0] hold_count_next;
  logic [2:0] bit_count_next;
  logic [7:0] shift_byte_next;
  logic [7:0] poll_count_next;
  logic       is_read_next;
  logic [7:0] latched_register_next;
  logic [7:0] latched_data_next;
  logic [7:0] received_byte_next;
  logic       scl_level_next;
  logic       sda_level_next;
  i2cram_pkg::res_t res_next;

  assign pop = pop_valid && (!out_valid || out_ready);

  always_comb begin
    logic            scl;
    logic            sdo;
    logic            drv;
    logic            done;
    logic            ok;
    logic            enter;
    logic [3:0]      epos;
    logic [3:0]      pos;
    logic [1:0]      sub;
    logic            run;
    i2cram_pkg::kind_t kind;
    i2cram_pkg::src_t  src;

    phase_next            = phase;
    hold_count_next       = hold_count;
    bit_count_next        = bit_count;
    shift_byte_next       = shift_byte;
    poll_count_next       = poll_count;
    is_read_next          = is_read;
    latched_register_next = latched_register;
    latched_data_next     = latched_data;
    received_byte_next    = received_byte;
    scl_level_next        = scl_level;
    sda_level_next        = sda_level;
    scl   = scl_level;
    sdo   = sda_level;
    drv   = 1'b1;
    done  = 1'b0;
    ok    = 1'b0;
    enter = 1'b0;
    epos  = 4'd0;
    run   = 1'b1;
    src   = i2cram_pkg::S_NONE;

    if (phase >= i2cram_pkg::PH_BUSY_END) begin
      if (pop_item.op == i2cram_pkg::OP_WRITE || pop_item.op == i2cram_pkg::OP_READ) begin
        latched_register_next = pop_item.reg_addr;
        latched_data_next     = pop_item.write_data;
        is_read_next          = (pop_item.op == i2cram_pkg::OP_READ);
        phase_next            = 6'd0;
        hold_count_next       = 2'd0;
        bit_count_next        = 3'd0;
        poll_count_next       = 8'd0;
        shift_byte_next       = 8'd0;
      end else begin
        run = 1'b0;
      end
    end

    pos  = phase_next[5:2];
    sub  = phase_next[1:0];
    kind = i2cram_pkg::prog_kind(is_read_next, pos);

    if (run) begin
      scl = 1'b0;
      sdo = 1'b1;
      case (kind)
        i2cram_pkg::K_START: begin
          case (sub)
            2'd0: begin
              scl = scl_level;
              hold_count_next = 2'd0;
              phase_next = phase_next + 6'd1;
            end
            2'd1, 2'd2: begin
              scl = 1'b1;
              sdo = (sub == 2'd1);
              if (hold_count_next >= 2'd1) begin
                hold_count_next = 2'd0;
                phase_next = phase_next + 6'd1;
              end else begin
                hold_count_next = hold_count_next + 2'd1;
              end
            end
            default: begin
              sdo = 1'b0;
              if (hold_count_next >= 2'd1) begin
                hold_count_next = 2'd0;
                enter = 1'b1;
                epos  = pos + 4'd1;
              end else begin
                hold_count_next = hold_count_next + 2'd1;
              end
            end
          endcase
        end
        i2cram_pkg::K_TX: begin
          sdo = shift_byte_next[7];
          scl = (sub == 2'd0);
          if (hold_count_next >= 2'd1) begin
            hold_count_next = 2'd0;
            if (sub == 2'd0) begin
              phase_next = phase_next + 6'd1;
            end else begin
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
              bit_count_next  = bit_count_next + 3'd1;
              if (bit_count_next == 3'd0) begin
                enter = 1'b1;
                epos  = pos + 4'd1;
              end else begin
                phase_next = {pos, 2'd0};
              end
            end
          end else begin
            hold_count_next = hold_count_next + 2'd1;
          end
        end
        i2cram_pkg::K_ACK: begin
          case (sub)
            2'd0: begin
              sdo = sda_level;
              phase_next = phase_next + 6'd1;
            end
            2'd1: begin
              phase_next = phase_next + 6'd1;
            end
            2'd2: begin
              scl = 1'b1;
              drv = 1'b0;
              if (!pop_item.sda_in) begin
                phase_next = phase_next + 6'd1;
              end else if (poll_count_next >= cfg.ack_timeout) begin
                enter = 1'b1;
                epos  = i2cram_pkg::POS_FAIL;
              end else begin
                poll_count_next = poll_count_next + 8'd1;
              end
            end
            default: begin
              drv   = 1'b0;
              enter = 1'b1;
              epos  = pos + 4'd1;
            end
          endcase
        end
        i2cram_pkg::K_RX: begin
          drv = 1'b0;
          if (sub == 2'd0) begin
            scl = 1'b1;
            shift_byte_next = {shift_byte_next[6:0], pop_item.sda_in};
            phase_next = phase_next + 6'd1;
          end else begin
            bit_count_next = bit_count_next + 3'd1;
            if (bit_count_next == 3'd0) begin
              received_byte_next = shift_byte_next;
              enter = 1'b1;
              epos  = pos + 4'd1;
            end else begin
              phase_next = {pos, 2'd0};
            end
          end
        end
        i2cram_pkg::K_NACK: begin
          scl = (sub != 2'd0);
          if (hold_count_next >= 2'd1) begin
            hold_count_next = 2'd0;
            if (sub == 2'd0) begin
              phase_next = phase_next + 6'd1;
            end else begin
              enter = 1'b1;
              epos  = pos + 4'd1;
            end
          end else begin
            hold_count_next = hold_count_next + 2'd1;
          end
        end
        default: begin
          case (sub)
            2'd0: begin
              sdo = 1'b0;
              hold_count_next = 2'd0;
              phase_next = phase_next + 6'd1;
            end
            2'd1: begin
              scl = 1'b1;
              sdo = 1'b0;
              if (hold_count_next >= 2'd1) begin
                hold_count_next = 2'd0;
                phase_next = phase_next + 6'd1;
              end else begin
                hold_count_next = hold_count_next + 2'd1;
              end
            end
            default: begin
              scl = 1'b1;
              if (hold_count_next >= 2'd1) begin
                hold_count_next = 2'd0;
                done = 1'b1;
                ok   = (pos != i2cram_pkg::POS_FAIL);
                phase_next = i2cram_pkg::PH_IDLE;
              end else begin
                hold_count_next = hold_count_next + 2'd1;
              end
            end
          endcase
        end
      endcase

      if (enter) begin
        if (epos > i2cram_pkg::POS_FAIL) begin
          epos = i2cram_pkg::POS_FAIL;
        end
        phase_next      = {epos, 2'd0};
        hold_count_next = 2'd0;
        bit_count_next  = 3'd0;
        poll_count_next = 8'd0;
        src = i2cram_pkg::prog_src(is_read_next, epos);
        case (src)
          i2cram_pkg::S_WADDR: shift_byte_next = cfg.write_address_byte;
          i2cram_pkg::S_REG:   shift_byte_next = latched_register_next;
          i2cram_pkg::S_DATA:  shift_byte_next = latched_data_next;
          i2cram_pkg::S_RADDR: shift_byte_next = cfg.read_address_byte;
          default:             shift_byte_next = 8'd0;
        endcase
      end

      if (!drv) begin
        sdo = 1'b1;
      end
      scl_level_next = scl;
      sda_level_next = sdo;
    end

    res_next.scl       = scl;
    res_next.sda_out   = sdo;
    res_next.sda_drive = drv;
    res_next.busy_res  = run;
    res_next.done_res  = done;
    res_next.success   = ok;
    res_next.read_data = received_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.write_address_byte <= i2cram_pkg::WRITE_ADDR_RESET;
      cfg.read_address_byte  <= i2cram_pkg::READ_ADDR_RESET;
      cfg.ack_timeout        <= i2cram_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cram_pkg::CFG_WRITE_ADDR: cfg.write_address_byte <= cfg_data;
        i2cram_pkg::CFG_READ_ADDR:  cfg.read_address_byte  <= cfg_data;
        i2cram_pkg::CFG_TIMEOUT:    cfg.ack_timeout        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= i2cram_pkg::PH_IDLE;
      hold_count       <= 2'd0;
      bit_count        <= 3'd0;
      shift_byte       <= 8'd0;
      poll_count       <= 8'd0;
      is_read          <= 1'b0;
      latched_register <= 8'd0;
      latched_data     <= 8'd0;
      received_byte    <= 8'd0;
      scl_level        <= 1'b1;
      sda_level        <= 1'b1;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        phase            <= phase_next;
        hold_count       <= hold_count_next;
        bit_count        <= bit_count_next;
        shift_byte       <= shift_byte_next;
        poll_count       <= poll_count_next;
        is_read          <= is_read_next;
        latched_register <= latched_register_next;
        latched_data     <= latched_data_next;
        received_byte    <= received_byte_next;
        scl_level        <= scl_level_next;
        sda_level        <= sda_level_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

endmodule

>>> design/i2c_register_access_master_top.sv
// Top level of the I2C register access master: input stage, queue and bus sequencer.
//
//   channel  direction  carries
//   s_*      in         one bus tick: command, register, data, sampled SDA
//   m_*      out        pin levels and status for that tick
//   cfg_*    in         register writes: address bytes and ACK timeout
//
// One item per clock is sustained while m_tready is high; each item is one bus tick.
// A result passes the input register, the queue and the output register before it is
// presented. The sequencer state updates once per item.
// Reset restores the register defaults, idles the sequencer and empties the queue.
// With m_tready low, the input register and the two-entry queue absorb items
// before s_tready drops.
module i2c_register_access_master_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // reg_addr[7:0], write_data[15:8], sda_in[16], zero
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl, sda_out, sda_drive, busy_res, done_res, success,
                                 // read_data[13:6], zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                push;
  logic                pop;
  i2cram_pkg::item_t   push_item;
  i2cram_pkg::item_t   pop_item;
  i2cram_pkg::q_stat_t q_stat;
  i2cram_pkg::res_t    res;

  i2cram_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_cmd        (s_tuser),
    .in_reg_addr   (s_tdata[7:0]),
    .in_write_data (s_tdata[15:8]),
    .in_sda        (s_tdata[16]),
    .push          (push),
    .push_item     (push_item),
    .q_stat        (q_stat)
  );

  i2cram_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  i2cram_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (q_stat.pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {2'b00, res.read_data, res.success, res.done_res, res.busy_res,
                    res.sda_drive, res.sda_out, res.scl};

`ifndef ASSERT_OFF
  a_release_high: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> m_tdata[1])
    else $error("released SDA not reported high");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[4] || m_tdata[5])) |-> (m_tdata[3] && m_tdata[4]))
    else $error("done or success outside a transaction");

  a_queue_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((q_stat.count == $past(q_stat.count)) ||
                     (q_stat.count == $past(q_stat.count) + 2'd1) ||
                     (q_stat.count == $past(q_stat.count) - 2'd1)))
    else $error("queue count jumped");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_stat.count != 2'd0))
    else $error("pop from empty queue");
`endif

endmodule
